// ===== hdl/sfsg_pkg.sv =====
// Shared types and constants for the steering frame sync generator.
`timescale 1ns / 1ps
package sfsg_pkg;

	localparam int FRAME_BYTES = 4;
	localparam int POS_W       = 2;
	localparam int INTRO_W     = 4;
	localparam int STEER_W     = 9;

	// One replacement frame, byte 0 goes out first
	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

	// Fixed off frames, chosen by the received counter bit
	localparam frame_t OFF_FRAME_0 = {8'hC0, 8'hC0, 8'h80, 8'h00};
	localparam frame_t OFF_FRAME_1 = {8'hA0, 8'hC0, 8'h80, 8'h20};

	localparam logic [INTRO_W-1:0] INTRO_RESET = 4'd5;

	// Saturation bounds of the steer value
	localparam logic signed [15:0] STEER_MAX = 16'sd255;
	localparam logic signed [15:0] STEER_MIN = -16'sd256;

	// Flag bits of the steer frame
	localparam logic [2:0] LOW_FLAGS  = 3'b101;
	localparam logic [7:0] FLAG_BYTE  = 8'h80;

endpackage

// ===== hdl/sfsg_frame_builder.sv =====
// Combinational builder of one replacement frame and the next intro count.
`timescale 1ns / 1ps
module sfsg_frame_builder (
	input  logic [7:0]                   rx_byte,
	input  logic                         steer_request,
	input  logic signed [15:0]           apply_steer,
	input  logic [sfsg_pkg::INTRO_W-1:0] intro_cfg,
	input  logic [sfsg_pkg::INTRO_W-1:0] intro_left,
	output sfsg_pkg::frame_t             frame,
	output logic [sfsg_pkg::INTRO_W-1:0] intro_next
);
	import sfsg_pkg::*;

	logic                      cnt_bit;
	logic signed [STEER_W-1:0] steer_sat;
	logic signed [STEER_W-1:0] steer_val;
	logic [7:0]                b0;
	logic [7:0]                b1;
	logic [9:0]                sum;
	logic [7:0]                chk;

	// a frame start always lands on position 0, so the counter bit is fresh
	assign cnt_bit = rx_byte[5];

	// saturate to -256..255
	always_comb begin
		if (apply_steer > STEER_MAX) begin
			steer_sat = STEER_MAX[STEER_W-1:0];
		end else if (apply_steer < STEER_MIN) begin
			steer_sat = STEER_MIN[STEER_W-1:0];
		end else begin
			steer_sat = apply_steer[STEER_W-1:0];
		end
	end

	// zero torque while the intro countdown runs
	assign steer_val = (intro_left != '0) ? '0 : steer_sat;

	// sign and 3 high bits, then 5 low bits with flags
	assign b0  = {2'b00, cnt_bit, 1'b0, steer_val[8], steer_val[7:5]};
	assign b1  = {LOW_FLAGS, steer_val[4:0]};
	assign sum = {2'b00, b0} + {2'b00, b1} + {2'b00, FLAG_BYTE};
	// (512 - sum mod 512) mod 256 is the low byte of the negated sum
	assign chk = 8'(10'd0 - sum);

	// frame select and countdown update
	always_comb begin
		if (!steer_request) begin
			frame      = cnt_bit ? OFF_FRAME_1 : OFF_FRAME_0;
			intro_next = intro_cfg;
		end else begin
			frame      = {chk, FLAG_BYTE, b1, b0};
			intro_next = (intro_left != '0) ? intro_left - 1'b1 : intro_left;
		end
	end

endmodule

// ===== hdl/sfsg_serializer.sv =====
// Pending frame buffer and byte serializer for the output stream.
`timescale 1ns / 1ps
module sfsg_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_valid,
	output logic             frame_ready,
	input  sfsg_pkg::frame_t frame,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);
	import sfsg_pkg::*;

	logic                          pend_valid_q;
	frame_t                        pend_q;
	logic                          out_valid_q;
	frame_t                        out_q;
	logic [$clog2(FRAME_BYTES)-1:0] out_cnt_q;
	logic                          out_xfer;
	logic                          out_done;
	logic                          load_out;
	logic                          pend_take;

	assign out_xfer  = out_valid_q && m_tready;
	assign out_done  = out_xfer && (out_cnt_q == $clog2(FRAME_BYTES)'(FRAME_BYTES - 1));
	assign load_out  = !out_valid_q || out_done;
	assign pend_take = load_out && pend_valid_q;

	assign frame_ready = !pend_valid_q || pend_take;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q[0];
	assign m_tlast  = (out_cnt_q == $clog2(FRAME_BYTES)'(FRAME_BYTES - 1));

	// control: pending slot and output run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_cnt_q    <= '0;
		end else begin
			if (frame_ready) begin
				pend_valid_q <= frame_valid;
			end
			if (load_out) begin
				out_valid_q <= pend_valid_q;
				out_cnt_q   <= '0;
			end else if (out_xfer) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end
		end
	end

	// payload: frame bytes shift out low byte first
	always_ff @(posedge clk) begin
		if (frame_ready && frame_valid) begin
			pend_q <= frame;
		end
		if (pend_take) begin
			out_q <= pend_q;
		end else if (out_xfer) begin
			out_q <= frame_t'(out_q >> 8);
		end
	end

endmodule

// ===== hdl/steer_frame_sync_generator.sv =====
// Top level: steering frame sync generator.
// Usage:
//  s_* stream: one transaction per received line byte. s_tdata holds
//  rx_byte [7:0] and apply_steer [23:8]; s_tuser is steer_request.
//  A byte with its top two bits clear starts a frame and produces a
//  four-byte replacement frame on the m_* stream; other bytes only move
//  the tracked byte position, latch the counter bit on a wrap to position 0, and produce nothing.
//  m_* stream: m_tdata is tx_byte, m_tlast marks the checksum byte.
//  cfg_we/cfg_data write intro_frames (zero-steer frames after an off frame).
//  Output: an accepted start byte's frame is registered in the pending slot,
//  then in the output register, before m_tvalid rises; the bytes then go out
//  one per cycle while m_tready is high.
//  Rate: a frame leaves one byte at a time over the single output byte lane;
//  input bytes are taken every cycle while the one-frame pending slot is free.
//  Reset: byte position 0, counter bit 0, intro countdown and register 5,
//  output stream empty.
//  Stall: when m_tready is low the current byte holds; once a frame waits in
//  the pending slot behind it, s_tready drops until the output moves on.
`timescale 1ns / 1ps
module steer_frame_sync_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [23:0]                  s_tdata,  // rx_byte [7:0], apply_steer [23:8]
	input  logic                         s_tuser,  // steer_request
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,  // tx_byte [7:0]
	output logic                         m_tlast,  // frame_last
	input  logic                         cfg_we,
	input  logic [sfsg_pkg::INTRO_W-1:0] cfg_data
);
	import sfsg_pkg::*;

	logic [7:0]         rx_byte;
	logic signed [15:0] apply_steer;
	logic               start;
	logic               s_xfer;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   pos_next;
	logic               cnt_bit_q;
	logic [INTRO_W-1:0] intro_left_q;
	logic [INTRO_W-1:0] intro_cfg_q;
	logic [INTRO_W-1:0] intro_next;
	frame_t             frame;

	assign rx_byte     = s_tdata[7:0];
	assign apply_steer = s_tdata[23:8];
	assign start       = (rx_byte[7:6] == 2'b00);
	assign s_xfer      = s_tvalid && s_tready;
	assign pos_next    = start ? '0 : pos_q + 1'b1;

	sfsg_frame_builder u_builder (
		.rx_byte       (rx_byte),
		.steer_request (s_tuser),
		.apply_steer   (apply_steer),
		.intro_cfg     (intro_cfg_q),
		.intro_left    (intro_left_q),
		.frame         (frame),
		.intro_next    (intro_next)
	);

	sfsg_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (s_tvalid && start),
		.frame_ready (s_tready),
		.frame       (frame),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	// line tracking state and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			cnt_bit_q    <= 1'b0;
			intro_left_q <= INTRO_RESET;
			intro_cfg_q  <= INTRO_RESET;
		end else begin
			if (cfg_we) begin
				intro_cfg_q <= cfg_data;
			end
			if (s_xfer) begin
				pos_q <= pos_next;
				if (pos_next == '0) begin
					cnt_bit_q <= rx_byte[5];
				end
				if (start) begin
					intro_left_q <= intro_next;
				end
			end
		end
	end

	// the input only stalls behind a busy output
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// a frame runs on until its checksum byte
	a_frame_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("frame cut short");

	// an off frame reloads the intro countdown
	a_intro_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && start && !s_tuser && !cfg_we |=> intro_left_q == intro_cfg_q)
		else $error("intro countdown not reloaded");

	// frame starts reset the byte position
	a_pos_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && start |=> pos_q == '0 && cnt_bit_q == $past(rx_byte[5]))
		else $error("frame start not tracked");

endmodule

// ===== dv/steer_frame_sync_generator_test.sv =====
// Testbench for the steering frame sync generator: directed and random line traffic.
`timescale 1ns / 1ps
module steer_frame_sync_generator_test;

	// Off frames, byte 0 in the low bits, picked by the received counter bit
	localparam logic [31:0] LINE_OFF_0   = 32'hC0C0_8000;
	localparam logic [31:0] LINE_OFF_1   = 32'hA0C0_8020;
	localparam logic signed [15:0] TORQUE_HI = 16'sd255;
	localparam logic signed [15:0] TORQUE_LO = -16'sd256;
	localparam logic [7:0] STEER_FLAGS  = 8'hA0;
	localparam logic [7:0] STEER_BYTE2  = 8'h80;
	localparam int WATCHDOG_LIMIT       = 2000;
	localparam int SETTLE_CYCLES        = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} reply_byte_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [23:0]                  s_tdata;  // rx_byte [7:0], apply_steer [23:8]
	logic                         s_tuser;  // steer_request
	logic                         m_tvalid;
	logic                         m_tready;
	logic [7:0]                   m_tdata;  // tx_byte [7:0]
	logic                         m_tlast;  // frame_last
	logic                         cfg_we;
	logic [sfsg_pkg::INTRO_W-1:0] cfg_data;

	// Predictor state
	logic [1:0]                   line_pos = 2'd0;
	logic                         line_cnt_bit = 1'b0;
	logic [3:0]                   intro_left = 4'd5;
	logic [3:0]                   intro_setting = 4'd5;
	reply_byte_t                  reply_q[$];

	int mismatch_count = 0;
	int idle_cycles = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int rx_wait_left = 0;
	int rx_hold_left = 0;
	int rx_hold_request = 0;

	steer_frame_sync_generator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Work out the replacement frame caused by one accepted line byte
	task automatic predict_reply_frame(input logic [7:0] rx, input logic req,
			input logic signed [15:0] steer);
		logic              start;
		logic [31:0]       frame;
		logic signed [15:0] torque;
		logic [3:0]        high;
		int                sum;
		start = (rx[7:6] == 2'b00);
		line_pos = start ? 2'd0 : line_pos + 2'd1;
		if (line_pos == 2'd0)
			line_cnt_bit = rx[5];
		if (start) begin
			if (!req) begin
				frame = line_cnt_bit ? LINE_OFF_1 : LINE_OFF_0;
				intro_left = intro_setting;
			end else begin
				torque = steer;
				if (torque > TORQUE_HI)
					torque = TORQUE_HI;
				else if (torque < TORQUE_LO)
					torque = TORQUE_LO;
				if (intro_left != 4'd0) begin
					torque = '0;
					intro_left = intro_left - 4'd1;
				end
				high = {torque < 0, torque[7:5]};
				frame[7:0]   = {2'b00, line_cnt_bit, 1'b0, high};
				frame[15:8]  = STEER_FLAGS | {3'b000, torque[4:0]};
				frame[23:16] = STEER_BYTE2;
				sum = (frame[7:0] + frame[15:8] + frame[23:16]) % 512;
				frame[31:24] = 8'((512 - sum) % 256);
			end
			for (int k = 0; k < 4; k++)
				reply_q.push_back('{data: frame[8*k +: 8], last: (k == 3)});
		end
	endtask

	// Offer one line byte, hold it until taken, then predict
	task automatic send_line_byte(input logic [7:0] rx, input logic req,
			input logic signed [15:0] steer);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {steer, rx};
		s_tuser  = req;
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		predict_reply_frame(rx, req, steer);
	endtask

	// Stop offering and let every expected byte come out
	task automatic wait_line_quiet;
		@(negedge clk);
		s_tvalid = 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_intro_frames(input logic [3:0] value);
		wait_line_quiet();
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we   = 1'b0;
		intro_setting = value;
	endtask

	function automatic logic [7:0] start_byte();
		return {2'b00, 6'($urandom)};
	endfunction

	function automatic logic [7:0] cont_byte();
		return {2'($urandom_range(1, 3)), 6'($urandom)};
	endfunction

	function automatic logic signed [15:0] rand_steer();
		logic signed [15:0] v;
		case ($urandom_range(0, 3))
			0: v = 16'($urandom);
			1: v = 16'(int'($urandom_range(0, 600)) - 300);
			2: v = 16'(int'($urandom_range(0, 64)) - 32);
			default: v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		endcase
		return v;
	endfunction

	function automatic logic rand_request();
		return ($urandom_range(0, 99) < 85);
	endfunction

	// Mostly whole frames, some cut short, some stray bytes
	task automatic random_traffic(input int n_items);
		int sent;
		int kind;
		int tail;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				tail = (kind < 7) ? 3 : $urandom_range(0, 2);
				send_line_byte(start_byte(), rand_request(), rand_steer());
				repeat (tail) send_line_byte(cont_byte(), rand_request(), rand_steer());
				sent += tail + 1;
			end else begin
				send_line_byte(8'($urandom), 1'($urandom_range(0, 1)), 16'($urandom));
				sent++;
			end
		end
	endtask

	// Intro countdown runs from its reset value
	task automatic test_intro_after_reset;
		for (int k = 0; k < 6; k++)
			send_line_byte(8'h00 | (k[0] << 5), 1'b1, -16'sd200);
	endtask

	// Both off frames, countdown reload
	task automatic test_off_frames;
		send_line_byte(8'h00, 1'b0, 16'sd100);
		send_line_byte(8'h20, 1'b0, 16'sd100);
		send_line_byte(8'h3F, 1'b0, -16'sd1);
	endtask

	// Position tracking, wrap onto zero without a frame start
	task automatic test_byte_position;
		send_line_byte(8'h1F, 1'b1, 16'sd50);
		send_line_byte(8'h40, 1'b1, 16'sd50);
		send_line_byte(8'h80, 1'b0, 16'sd50);
		send_line_byte(8'hFF, 1'b1, 16'sd50);
		send_line_byte(8'hE0, 1'b1, 16'sd50);
		send_line_byte(8'h7F, 1'b0, 16'sd50);
	endtask

	// Saturation bounds and packing of the steer value
	task automatic test_steer_saturation;
		logic signed [15:0] values [10];
		values = '{16'sh7FFF, 16'sh8000, 16'sd255, 16'sd256, -16'sd256,
			-16'sd257, 16'sd0, -16'sd1, 16'sd31, -16'sd32};
		write_intro_frames(4'd0);
		for (int k = 0; k < 10; k++)
			send_line_byte({2'b00, k[0], 5'(k)}, 1'b1, values[k]);
	endtask

	task automatic test_random_long_intro;
		write_intro_frames(4'd15);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		random_traffic(50);
	endtask

	task automatic test_random_back_to_back;
		write_intro_frames(4'd0);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		random_traffic(40);
	endtask

	// Receiver holds off while start bytes keep coming
	task automatic test_output_backpressure;
		tx_idle_en = 1'b0;
		rx_hold_request = 150;
		repeat (20) send_line_byte(start_byte(), rand_request(), rand_steer());
	endtask

	task automatic test_random_mixed;
		write_intro_frames(4'($urandom_range(1, 14)));
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		random_traffic(35);
	endtask

	task automatic test_random_short_intro;
		write_intro_frames(4'd1);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b0;
		random_traffic(40);
	endtask

	// Receiver ready: per-byte wait and the long hold-off
	always @(negedge clk) begin
		if (rx_hold_request > 0) begin
			rx_hold_left = rx_hold_request;
			rx_hold_request = 0;
		end
		if (rx_hold_left > 0) begin
			m_tready = 1'b0;
			rx_hold_left--;
		end else if (rx_wait_left > 0) begin
			m_tready = 1'b0;
			rx_wait_left--;
		end else begin
			m_tready = 1'b1;
		end
	end

	// Compare each output transaction with the oldest expected byte
	always @(posedge clk) begin
		reply_byte_t exp_byte;
		if (arst_n && m_tvalid && m_tready) begin
			rx_wait_left = rx_idle_en ? $urandom_range(0, 6) : 0;
			if (reply_q.size() == 0) begin
				$display("%0t: unexpected output byte %02h, last %0b", $time, m_tdata,
					m_tlast);
				mismatch_count++;
			end else begin
				exp_byte = reply_q.pop_front();
				if (m_tdata !== exp_byte.data) begin
					$display("%0t: tx_byte mismatch, expected %02h, actual %02h", $time,
						exp_byte.data, m_tdata);
					mismatch_count++;
				end
				if (m_tlast !== exp_byte.last) begin
					$display("%0t: frame_last mismatch, expected %0b, actual %0b", $time,
						exp_byte.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress, %0d bytes still expected", $time,
					reply_q.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_intro_after_reset();
		test_off_frames();
		test_byte_position();
		test_steer_saturation();
		test_random_long_intro();
		test_random_back_to_back();
		test_output_backpressure();
		test_random_mixed();
		test_random_short_intro();

		wait_line_quiet();
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
